// ===== design/ols_pkg.sv =====
package ols_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_FIND,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [6:0]         position;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] found_position;
    logic [6:0] element_count;
  } out_beat_t;

endpackage

// ===== design/ols_cell.sv =====
module ols_cell #(
  parameter int AW    = 6,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  ols_pkg::cell_ctl_t  ctl,
  input  logic [AW-1:0]       at,
  input  logic signed [31:0]  left_data,
  input  logic signed [31:0]  right_data,
  input  logic                right_match,
  output logic signed [31:0]  data,
  output logic                match
);

  localparam logic [AW-1:0] MY_INDEX = AW'(INDEX);

  logic signed [31:0] data_next;
  logic               match_next;

  always_comb begin
    data_next  = data;
    match_next = match;
    case (ctl.op)
      ols_pkg::CELL_INSERT: begin
        // open the gap: cells past the slot take their left neighbor
        if (MY_INDEX > at) begin
          data_next = left_data;
        end else if (MY_INDEX == at) begin
          data_next = ctl.value;
        end
      end
      ols_pkg::CELL_ERASE: begin
        if (MY_INDEX >= at) begin
          data_next = right_data;
        end
      end
      ols_pkg::CELL_FIND: match_next = (data == ctl.value);
      ols_pkg::CELL_SCAN: match_next = right_match;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data  <= data_next;
    match <= match_next;
  end

endmodule

// ===== design/ordered_list_store.sv =====
// Ordered list of up to LIST_DEPTH signed 32-bit values held in a chain of
// cells, one element per cell. For push, pop front, insert and erase the
// cells from the slot on move at once, taking their left or right neighbor
// to open or close a gap; pop back only lowers the count. In a find all cells
// compare at once, then the match bits shift toward the head of the chain one
// place per cycle until the first match or the last element reaches the head.
// Find in an empty list answers without a scan. One command is in work at a
// time; a new beat is taken once the command before it has left the result
// register or is leaving it in the same cycle. No clearing is needed after
// reset, since only cells below the count are ever read.
module ordered_list_store #(
  parameter int LIST_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ols_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ols_pkg::out_beat_t out_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] FULL_COUNT = CW'(LIST_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      scan_pos;

  logic signed [31:0] cell_data  [LIST_DEPTH];
  logic               cell_match [LIST_DEPTH];

  ols_pkg::cell_ctl_t ctl;
  logic [AW-1:0]      at;

  logic               slot_free;
  logic               accept;
  logic               full;
  logic               empty;
  logic [PW-1:0]      pos_w;
  logic [PW-1:0]      cnt_w;
  logic [PW-1:0]      count_out_w;
  logic [PW-1:0]      found_w;
  logic [1:0]         status_next;
  logic [CW-1:0]      count_next;
  logic               start_scan;
  ols_pkg::cell_op_t  accept_op;
  logic [AW-1:0]      accept_at;
  logic               scan_last;
  logic               scan_hit;
  logic               scan_end;
  logic               out_load;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = !rst && (state == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign pos_w     = PW'(in_data.position);
  assign cnt_w     = PW'(count);

  always_comb begin
    status_next = ols_pkg::ST_DONE;
    count_next  = count;
    start_scan  = 1'b0;
    accept_op   = ols_pkg::CELL_HOLD;
    accept_at   = AW'(pos_w - PW'(1));
    case (in_data.command)
      ols_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          status_next = ols_pkg::ST_FULL;
        end else begin
          accept_op  = ols_pkg::CELL_INSERT;
          accept_at  = count[AW-1:0];
          count_next = count + CW'(1);
        end
      end
      ols_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status_next = ols_pkg::ST_FULL;
        end else begin
          accept_op  = ols_pkg::CELL_INSERT;
          accept_at  = '0;
          count_next = count + CW'(1);
        end
      end
      ols_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_next = ols_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      ols_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status_next = ols_pkg::ST_EMPTY;
        end else begin
          accept_op  = ols_pkg::CELL_ERASE;
          accept_at  = '0;
          count_next = count - CW'(1);
        end
      end
      ols_pkg::CMD_INSERT: begin
        if (full) begin
          status_next = ols_pkg::ST_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
          status_next = ols_pkg::ST_RANGE;
        end else begin
          accept_op  = ols_pkg::CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      ols_pkg::CMD_ERASE: begin
        if (empty) begin
          status_next = ols_pkg::ST_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          status_next = ols_pkg::ST_RANGE;
        end else begin
          accept_op  = ols_pkg::CELL_ERASE;
          count_next = count - CW'(1);
        end
      end
      ols_pkg::CMD_FIND: begin
        if (!empty) begin
          accept_op  = ols_pkg::CELL_FIND;
          start_scan = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // scan ends on a hit at the head cell or once the last element was checked
  assign scan_hit  = cell_match[0];
  assign scan_last = (CW'(scan_pos + CW'(1)) == count);
  assign scan_end  = scan_hit || scan_last;

  always_comb begin
    ctl.value = in_data.value;
    ctl.op    = ols_pkg::CELL_HOLD;
    at        = accept_at;
    if (accept) begin
      ctl.op = accept_op;
    end else if (state == S_SCAN && !scan_end) begin
      ctl.op = ols_pkg::CELL_SCAN;
    end
  end

  assign count_out_w = PW'(count_next);
  assign found_w     = scan_hit ? PW'(CW'(scan_pos + CW'(1))) : '0;
  assign out_load    = (accept && !start_scan) ||
                       (state == S_SCAN && scan_end && slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      scan_pos  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (start_scan) begin
              state    <= S_SCAN;
              scan_pos <= '0;
            end else begin
              out_data.status         <= status_next;
              out_data.found_position <= '0;
              out_data.element_count  <= count_out_w[6:0];
              count                   <= count_next;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            // hold the match bits until the result register frees up
            if (slot_free) begin
              out_data.status         <= ols_pkg::ST_DONE;
              out_data.found_position <= found_w[6:0];
              out_data.element_count  <= cnt_w[6:0];
              state                   <= S_IDLE;
            end
          end else begin
            scan_pos <= scan_pos + CW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [31:0] left_data;
    logic signed [31:0] right_data;
    logic               right_match;

    if (i == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_match = 1'b0;
    end else begin : g_body
      assign right_data  = cell_data[i+1];
      assign right_match = cell_match[i+1];
    end

    ols_cell #(
      .AW    (AW),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .at          (at),
      .left_data   (left_data),
      .right_data  (right_data),
      .right_match (right_match),
      .data        (cell_data[i]),
      .match       (cell_match[i])
    );
  end

endmodule
